// ===== design/uozv_pkg.sv =====
// ----------------------------------------------------------------------------
// uozv_pkg
// Shared types and constants for the ultrasonic obstacle zone voter.
// ----------------------------------------------------------------------------
package uozv_pkg;

  localparam int unsigned NumChan    = 4;
  localparam logic [15:0] SadLimit   = 16'd5000;
  localparam logic [15:0] HiLevel    = 16'd500;
  localparam logic [7:0]  SlowSpeed  = 8'd8;
  localparam logic [7:0]  FastSpeed  = 8'd10;

  localparam logic [1:0] ZoneA = 2'd0;
  localparam logic [1:0] ZoneB = 2'd1;
  localparam logic [1:0] ZoneC = 2'd2;
  localparam logic [1:0] ZoneD = 2'd3;

  localparam logic [2:0] RegFrontStarts = 3'd0;
  localparam logic [2:0] RegFrontEnds   = 3'd1;
  localparam logic [2:0] RegRearStarts  = 3'd2;
  localparam logic [2:0] RegRearEnds    = 3'd3;
  localparam logic [2:0] RegFrontShift  = 3'd4;
  localparam logic [2:0] RegRearShift   = 3'd5;

  typedef enum logic [2:0] {
    StIdle,
    StNoise,
    StVote,
    StSelect,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // write samples, clear accumulators
    logic scan;    // process one window position
    logic first;   // first position of a scan pass
    logic fin;     // decide zones and update state
  } dp_cmd_t;

endpackage

// ===== design/uozv_ctrl.sv =====
// ----------------------------------------------------------------------------
// uozv_ctrl
// Sequencer: noise pass over the window, vote pass, zone decision, output.
// ----------------------------------------------------------------------------
module uozv_ctrl import uozv_pkg::*; #(
  parameter int unsigned CW = 5,
  parameter int unsigned WindowDepth = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dp_cmd_t       cmd_o,
  output logic [CW-1:0] cnt_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last;

  assign last  = (cnt_q == CW'(WindowDepth - 1));
  assign cnt_o = cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StNoise;
          cnt_d   = '0;
        end
      end
      StNoise: begin
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = StVote;
          cnt_d   = '0;
        end
      end
      StVote: begin
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = StSelect;
        end
      end
      StSelect: state_d = StOut;
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StNoise: begin
        cmd_o.scan  = 1'b1;
        cmd_o.first = (cnt_q == '0);
      end
      StVote:   cmd_o.scan = 1'b1;
      StSelect: cmd_o.fin = 1'b1;
      StOut:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // a pass never runs past the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNoise || state_q == StVote) |-> cnt_q < CW'(WindowDepth))
    else $error("scan index out of range");
  // an accepted item always starts a noise pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StNoise && cnt_q == '0))
    else $error("accept did not start pass");
  // result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");

endmodule

// ===== design/uozv_dp.sv =====
// ----------------------------------------------------------------------------
// uozv_dp
// Datapath: four ring windows, noise accumulators, zone vote counters,
// zone decision and entry counter.
// ----------------------------------------------------------------------------
module uozv_dp import uozv_pkg::*; #(
  parameter int unsigned CW = 5,
  parameter int unsigned WindowDepth = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [1:0]    phase_vote_i,
  input  logic [15:0]   dist_i [NumChan],
  input  logic [7:0]    speed_i,
  input  logic          rental_i,
  input  logic [63:0]   fs_i,
  input  logic [63:0]   fe_i,
  input  logic [63:0]   rs_i,
  input  logic [63:0]   re_i,
  input  logic [6:0]    fshift_i,
  input  logic [6:0]    rshift_i,
  output logic [1:0]    front_zone_o,
  output logic [1:0]    rear_zone_o,
  output logic [NumChan-1:0] noisy_o,
  output logic [15:0]   count_o
);

  localparam int unsigned AW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned VW = CW + 1; // holds 2*WindowDepth

  logic [15:0]   win_q [NumChan][WindowDepth];
  logic [AW-1:0] slot_q;
  logic [7:0]    speed_q;
  logic          rental_q;
  logic [15:0]   sad_q [NumChan];
  logic [15:0]   prev_q [NumChan];
  logic [CW-1:0] hi_q [NumChan];
  logic [CW-1:0] lo_q [NumChan];
  logic [NumChan-1:0] noisy_q;
  logic [NumChan-1:0] noisy_d;
  logic [VW-1:0] fcnt_q [4];
  logic [VW-1:0] rcnt_q [4];
  logic [1:0]    fz_q, rz_q;
  logic [15:0]   ecnt_q;

  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_idx;
  logic          vote_phase;

  // scan starts at the oldest sample, i.e. the current slot after advance
  assign rd_sum     = {1'b0, slot_q} + (AW+1)'(cnt_i);
  assign rd_idx     = (rd_sum >= (AW+1)'(WindowDepth)) ?
                      AW'(rd_sum - (AW+1)'(WindowDepth)) : AW'(rd_sum);
  assign vote_phase = phase_vote_i[0];

  // windows and slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        for (int i = 0; i < WindowDepth; i++) begin
          win_q[c][i] <= '0;
        end
      end
      slot_q   <= '0;
      speed_q  <= '0;
      rental_q <= 1'b0;
    end else if (cmd_i.load) begin
      for (int c = 0; c < NumChan; c++) begin
        win_q[c][slot_q] <= dist_i[c];
      end
      slot_q   <= (slot_q == AW'(WindowDepth - 1)) ? '0 : slot_q + 1'b1;
      speed_q  <= speed_i;
      rental_q <= rental_i;
    end
  end

  // per-channel scan logic
  logic [15:0] samp [NumChan];
  logic [15:0] aend [NumChan];
  logic [NumChan-1:0] hit [4];
  logic signed [17:0] lb [2][4];
  logic signed [17:0] ub [2][4];
  logic [6:0] sh [2];

  always_comb begin
    sh[0] = (speed_q == '0) ? fshift_i : '0;
    sh[1] = (speed_q == '0) ? rshift_i : '0;
    for (int z = 0; z < 4; z++) begin
      lb[0][z] = (z == 0) ? $signed({2'b00, fs_i[16*z +: 16]})
                          : $signed({2'b00, fs_i[16*z +: 16]}) - $signed({11'd0, sh[0]});
      ub[0][z] = $signed({2'b00, fe_i[16*z +: 16]}) - $signed({11'd0, sh[0]});
      lb[1][z] = (z == 0) ? $signed({2'b00, rs_i[16*z +: 16]})
                          : $signed({2'b00, rs_i[16*z +: 16]}) - $signed({11'd0, sh[1]});
      ub[1][z] = $signed({2'b00, re_i[16*z +: 16]}) - $signed({11'd0, sh[1]});
    end
    for (int c = 0; c < NumChan; c++) begin
      samp[c] = (rd_idx == slot_q && cmd_i.load) ? '0 : win_q[c][rd_idx];
      aend[c] = (c < 2) ? fe_i[15:0] : re_i[15:0];
      // first vote cycle: take the fresh verdict before it is registered
      for (int z = 0; z < 4; z++) begin
        hit[z][c] = !((cnt_i == '0) ? noisy_d[c] : noisy_q[c]) &&
                    $signed({2'b00, samp[c]}) >= lb[c/2][z] &&
                    $signed({2'b00, samp[c]}) <= ub[c/2][z];
      end
    end
  end

  // noise accumulators and vote counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int z = 0; z < 4; z++) begin
        fcnt_q[z] <= '0;
        rcnt_q[z] <= '0;
      end
    end else if (cmd_i.scan && !vote_phase) begin
      for (int c = 0; c < NumChan; c++) begin
        if (cmd_i.first) begin
          sad_q[c] <= '0;
          hi_q[c]  <= CW'(samp[c] >= HiLevel);
          lo_q[c]  <= CW'(samp[c] <= aend[c]);
        end else begin
          sad_q[c] <= sad_q[c] + ((prev_q[c] >= samp[c]) ? prev_q[c] - samp[c]
                                                         : samp[c] - prev_q[c]);
          hi_q[c]  <= hi_q[c] + CW'(samp[c] >= HiLevel);
          lo_q[c]  <= lo_q[c] + CW'(samp[c] <= aend[c]);
        end
        prev_q[c] <= samp[c];
      end
    end else if (cmd_i.scan && vote_phase) begin
      for (int z = 0; z < 4; z++) begin
        fcnt_q[z] <= fcnt_q[z] + VW'(hit[z][0]) + VW'(hit[z][1]);
        rcnt_q[z] <= rcnt_q[z] + VW'(hit[z][2]) + VW'(hit[z][3]);
      end
    end
  end

  // noise verdict, taken at the first vote cycle
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      noisy_d[c] = (sad_q[c] > SadLimit) ||
        (((VW+2)'(hi_q[c]) + (VW+2)'(lo_q[c])) * 4 >= (VW+2)'(3 * WindowDepth) &&
         hi_q[c] >= CW'(WindowDepth / 4) && lo_q[c] <= CW'(WindowDepth / 2) &&
         lo_q[c] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noisy_q <= '0;
    end else if (cmd_i.scan && vote_phase && cnt_i == '0) begin
      noisy_q <= noisy_d;
    end
  end

  // zone selection
  function automatic logic [1:0] pick(input logic [VW-1:0] c0, input logic [VW-1:0] c1,
                                      input logic [VW-1:0] c2, input logic [VW-1:0] c3);
    logic [VW-1:0] best;
    logic [1:0]    area;
    best = VW'(1);
    area = ZoneD;
    if (c3 > VW'(2 * WindowDepth - 1)) begin
      return ZoneD;
    end
    if (c0 > best) begin best = c0; area = ZoneA; end
    if (c1 > best) begin best = c1; area = ZoneB; end
    if (c2 > best) begin area = ZoneC; end
    return area;
  endfunction

  logic [1:0] fsel, fz_d, rz_d;
  logic       inc;
  always_comb begin
    fsel = pick(fcnt_q[0], fcnt_q[1], fcnt_q[2], fcnt_q[3]);
    rz_d = pick(rcnt_q[0], rcnt_q[1], rcnt_q[2], rcnt_q[3]);
    if (fz_q == ZoneB && fsel == ZoneD && speed_q <= SlowSpeed) fsel = ZoneC;
    if (fz_q == ZoneD && fsel == ZoneB && speed_q > SlowSpeed) fsel = ZoneC;
    if (speed_q > FastSpeed) fsel = ZoneD;
    inc  = (fz_q != ZoneA) && (fsel == ZoneA);
    fz_d = rental_q ? ZoneD : fsel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fz_q   <= ZoneD;
      rz_q   <= ZoneD;
      ecnt_q <= '0;
    end else if (cmd_i.fin) begin
      fz_q   <= fz_d;
      rz_q   <= rz_d;
      ecnt_q <= ecnt_q + 16'(inc);
    end
  end

  assign front_zone_o = fz_q;
  assign rear_zone_o  = rz_q;
  assign noisy_o      = noisy_q;
  assign count_o      = ecnt_q;

  // counter moves only on a decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.fin) |-> $stable(ecnt_q))
    else $error("entry counter moved outside decision");
  // rental mode leaves front at D
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && rental_q) |=> fz_q == ZoneD)
    else $error("rental did not force zone D");

endmodule

// ===== design/ultrasonic_obstacle_zone_voter.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_zone_voter
// Windows four ultrasonic channels, rejects noisy ones and votes front and
// rear obstacle zones.
//
//   channel | signals                          | role
//   in      | in_valid_i / in_ready_o          | one four-sensor reading
//   out     | out_valid_o / out_ready_i        | zones, noise flags, count
//   cfg     | cfg_valid_i / cfg_ready_o        | register index and data
//
// An item takes one noise pass and one vote pass over the window, each one
// sample a cycle, then a zone decision, then the wait for the output transfer.
// One item is in flight at a time; the next is taken after the result
// transfer. Reset clears windows, slot, zones (to D) and the counter.
// Config writes are always taken.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_zone_voter import uozv_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] front_left_dist_i,
  input  logic [15:0] front_right_dist_i,
  input  logic [15:0] rear_left_dist_i,
  input  logic [15:0] rear_right_dist_i,
  input  logic [7:0]  vehicle_speed_i,
  input  logic        rental_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  front_zone_o,
  output logic [1:0]  rear_zone_o,
  output logic        front_left_noisy_o,
  output logic        front_right_noisy_o,
  output logic        rear_left_noisy_o,
  output logic        rear_right_noisy_o,
  output logic [15:0] collision_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  logic [63:0] fs_q, fe_q, rs_q, re_q;
  logic [6:0]  fsh_q, rsh_q;
  dp_cmd_t     cmd;
  logic [CW-1:0] cnt;
  logic [1:0]  phase;
  logic [15:0] reading [NumChan];
  logic [NumChan-1:0] noisy;
  logic        vote_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0; fe_q <= '0; rs_q <= '0; re_q <= '0;
      fsh_q <= '0; rsh_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrontStarts: fs_q  <= cfg_data_i;
        RegFrontEnds:   fe_q  <= cfg_data_i;
        RegRearStarts:  rs_q  <= cfg_data_i;
        RegRearEnds:    re_q  <= cfg_data_i;
        RegFrontShift:  fsh_q <= cfg_data_i[6:0];
        RegRearShift:   rsh_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // track which pass the scan belongs to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vote_q <= 1'b0;
    end else if (cmd.load) begin
      vote_q <= 1'b0;
    end else if (cmd.scan && !vote_q && cnt == CW'(WINDOW_DEPTH - 1)) begin
      vote_q <= 1'b1;
    end
  end
  assign phase = {1'b0, vote_q};

  assign reading[0] = front_left_dist_i;
  assign reading[1] = front_right_dist_i;
  assign reading[2] = rear_left_dist_i;
  assign reading[3] = rear_right_dist_i;

  uozv_ctrl #(.CW(CW), .WindowDepth(WINDOW_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .cnt_o(cnt)
  );

  uozv_dp #(.CW(CW), .WindowDepth(WINDOW_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cnt_i(cnt), .phase_vote_i(phase),
    .dist_i(reading), .speed_i(vehicle_speed_i), .rental_i(rental_mode_i),
    .fs_i(fs_q), .fe_i(fe_q), .rs_i(rs_q), .re_i(re_q),
    .fshift_i(fsh_q), .rshift_i(rsh_q),
    .front_zone_o, .rear_zone_o, .noisy_o(noisy), .count_o(collision_count_o)
  );

  assign front_left_noisy_o  = noisy[0];
  assign front_right_noisy_o = noisy[1];
  assign rear_left_noisy_o   = noisy[2];
  assign rear_right_noisy_o  = noisy[3];

endmodule
